// ===== hw/rtl/tcgr_pkg.sv =====
`timescale 1ns / 1ps

package tcgr_pkg;

	// Fixed geometry of a character cell and of the framebuffer pixels.
	localparam int CURSOR_W   = 10;
	localparam int CELL_W     = 9;
	localparam int PIX_BYTES  = 4;
	localparam int CELL_BYTES = CELL_W * PIX_BYTES;
	localparam int ADDR_W     = 48;
	localparam int COL_OFF_W  = 16;

	// Defaults for the module parameters.
	localparam int DEF_GLYPH_ROWS  = 16;
	localparam int DEF_GLYPH_COUNT = 256;

	// Item codes.
	localparam logic       FUNC_LOAD  = 1'b0;
	localparam logic       FUNC_PRINT = 1'b1;
	localparam logic [7:0] CHAR_NEWLINE = 8'd10;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PITCH_BYTES   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd3;

	typedef struct packed {
		logic        func;
		logic [11:0] font_address;
		logic [7:0]  font_byte;
		logic [7:0]  char_code;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] write_address;
		logic [7:0]        ink_mask;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] base_address;
		logic [15:0]       pitch_bytes;
		logic [13:0]       screen_width;
		logic [13:0]       screen_height;
	} cfg_t;

	// One character to draw, at the cursor it was printed at.
	typedef struct packed {
		logic [7:0]          char_code;
		logic [CURSOR_W-1:0] row;
		logic [CURSOR_W-1:0] col;
	} job_t;

endpackage

// ===== hw/rtl/tcgr_ram.sv =====
`timescale 1ns / 1ps

module tcgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port; a read returns the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/tcgr_queue.sv =====
`timescale 1ns / 1ps

module tcgr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tcgr_pkg::job_t  push_job,
	input  logic            pop,
	output tcgr_pkg::job_t  head_job,
	output logic            full,
	output logic            empty
);

	import tcgr_pkg::*;

	job_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign head_job = entry_q[rd_ptr_q];

	// Two-entry queue of characters between the front and the back end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ===== hw/rtl/tcgr_front.sv =====
`timescale 1ns / 1ps

module tcgr_front #(
	parameter int GLYPH_ROWS  = tcgr_pkg::DEF_GLYPH_ROWS,
	parameter int GLYPH_COUNT = tcgr_pkg::DEF_GLYPH_COUNT
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         push,
	output logic                                         full,
	input  tcgr_pkg::in_item_t                           in_item,
	input  tcgr_pkg::cfg_t                               cfg,
	input  logic                                         reads_idle,
	input  logic                                         job_full,
	output logic                                         job_push,
	output tcgr_pkg::job_t                               job,
	output logic                                         font_we,
	output logic [$clog2(GLYPH_COUNT*GLYPH_ROWS)-1:0]    font_waddr,
	output logic [7:0]                                   font_wdata
);

	import tcgr_pkg::*;

	localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
	localparam int FONT_AW    = $clog2(FONT_DEPTH);
	localparam int COL_SPAN_W = 15;
	localparam int ROW_SPAN_W = $clog2(1024 * GLYPH_ROWS + 1);

	in_item_t            item_q;
	logic                item_valid_q;
	logic [CURSOR_W-1:0] col_q;
	logic [CURSOR_W-1:0] row_q;

	logic                is_load;
	logic                is_newline;
	logic                go;
	logic                load_in_range;
	logic [CURSOR_W-1:0] col_inc;
	logic [COL_SPAN_W-1:0] col_span;
	logic                col_wrap;
	logic [CURSOR_W-1:0] row_adv;
	logic [CURSOR_W-1:0] col_adv;
	logic [ROW_SPAN_W-1:0] row_span;
	logic                bottom_wrap;

	// Classify the held item and decide whether it can leave this cycle.
	// A font load waits until no queued character still has glyph rows to read.
	assign is_load    = (item_q.func == FUNC_LOAD);
	assign is_newline = (item_q.char_code == CHAR_NEWLINE);

	always_comb begin
		if (is_load) begin
			go = item_valid_q && reads_idle;
		end else if (is_newline) begin
			go = item_valid_q;
		end else begin
			go = item_valid_q && !job_full;
		end
	end

	assign full = item_valid_q && !go;

	// Font store write; addresses beyond the store are dropped.
	assign load_in_range = (32'(item_q.font_address) < 32'(FONT_DEPTH));
	assign font_we       = go && is_load && load_in_range;
	assign font_waddr    = FONT_AW'(32'(item_q.font_address));
	assign font_wdata    = item_q.font_byte;

	// Characters other than a newline go to the back end with the current cursor.
	assign job_push      = go && !is_load && !is_newline;
	assign job.char_code = item_q.char_code;
	assign job.row       = row_q;
	assign job.col       = col_q;

	// Cursor advance: wrap to the next line when the next cell would not fit.
	assign col_inc  = col_q + CURSOR_W'(1);
	assign col_span = COL_SPAN_W'({1'b0, col_inc} + 11'd1) * COL_SPAN_W'(CELL_W);
	assign col_wrap = (col_span > COL_SPAN_W'(cfg.screen_width));

	always_comb begin
		if (is_newline || col_wrap) begin
			row_adv = row_q + CURSOR_W'(1);
			col_adv = '0;
		end else begin
			row_adv = row_q;
			col_adv = col_inc;
		end
	end

	// Back to the top when the line's cell would run past the bottom.
	assign row_span    = ROW_SPAN_W'({1'b0, row_adv} + 11'd1) * ROW_SPAN_W'(GLYPH_ROWS);
	assign bottom_wrap = (row_span > ROW_SPAN_W'(cfg.screen_height));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_q <= 1'b0;
			col_q        <= '0;
			row_q        <= '0;
		end else begin
			if (push && !full) begin
				item_valid_q <= 1'b1;
			end else if (go) begin
				item_valid_q <= 1'b0;
			end
			if (go && !is_load) begin
				if (bottom_wrap) begin
					row_q <= '0;
					col_q <= '0;
				end else begin
					row_q <= row_adv;
					col_q <= col_adv;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			item_q <= in_item;
		end
	end

endmodule

// ===== hw/rtl/tcgr_back.sv =====
`timescale 1ns / 1ps

module tcgr_back #(
	parameter int GLYPH_ROWS  = tcgr_pkg::DEF_GLYPH_ROWS,
	parameter int GLYPH_COUNT = tcgr_pkg::DEF_GLYPH_COUNT
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  tcgr_pkg::cfg_t                               cfg,
	input  tcgr_pkg::job_t                               head_job,
	input  logic                                         job_empty,
	output logic                                         job_pop,
	output logic                                         active,
	output logic                                         font_re,
	output logic [$clog2(GLYPH_COUNT*GLYPH_ROWS)-1:0]    font_raddr,
	input  logic [7:0]                                   font_rdata,
	output logic                                         empty,
	input  logic                                         pop,
	output tcgr_pkg::out_item_t                          out_item
);

	import tcgr_pkg::*;

	localparam int FONT_AW = $clog2(GLYPH_COUNT * GLYPH_ROWS);
	localparam int ROW_W   = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
	localparam int Y_W     = $clog2(1024 * GLYPH_ROWS);
	localparam int PROD_W  = Y_W + 16;
	localparam int SUM_W   = PROD_W + 1;

	// Row sequencer state.
	logic                active_q;
	logic [ROW_W-1:0]    r_q;
	logic [FONT_AW-1:0]  glyph_base_q;
	logic [CURSOR_W-1:0] row_q;
	logic [CURSOR_W-1:0] col_q;

	// Pipeline registers.
	logic                valid_s2, valid_s3, valid_s4, out_valid_q;
	logic [Y_W-1:0]      y_s2;
	logic [CURSOR_W-1:0] col_s2;
	logic                last_s2, last_s3, last_s4;
	logic [PROD_W-1:0]   prod_s3;
	logic [COL_OFF_W-1:0] col_off_s3;
	logic [7:0]          mask_s3, mask_s4;
	logic [SUM_W-1:0]    sum_s4;

	logic                advance;
	logic                last_row;
	logic                load_job;
	logic [8:0]          char_ext;
	logic [8:0]          glyph_idx;
	logic [15:0]         pitch4;

	// The whole pipeline moves while the output register is free or being taken.
	assign advance  = !out_valid_q || pop;
	assign last_row = (r_q == ROW_W'(GLYPH_ROWS - 1));
	assign load_job = advance && !job_empty && (!active_q || last_row);
	assign job_pop  = load_job;
	assign active   = active_q;

	// Glyph index is the character code, less the glyph count once when it is not below it.
	assign char_ext  = {1'b0, head_job.char_code};
	assign glyph_idx = (char_ext >= 9'(GLYPH_COUNT)) ? char_ext - 9'(GLYPH_COUNT) : char_ext;

	assign font_re    = advance;
	assign font_raddr = glyph_base_q + FONT_AW'(r_q);

	assign pitch4 = {cfg.pitch_bytes[15:2], 2'b00};

	// Row sequencer: one glyph row per cycle while the pipeline advances; next job taken on the last row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			r_q      <= '0;
		end else if (load_job) begin
			active_q <= 1'b1;
			r_q      <= '0;
		end else if (advance && active_q) begin
			if (last_row) begin
				active_q <= 1'b0;
			end else begin
				r_q <= r_q + ROW_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_job) begin
			glyph_base_q <= FONT_AW'(glyph_idx) * FONT_AW'(GLYPH_ROWS);
			row_q        <= head_job.row;
			col_q        <= head_job.col;
		end
	end

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s2    <= active_q;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	// Address arithmetic: scan line, then pitch product and column offset, then their sum, then base.
	always_ff @(posedge clk) begin
		if (advance) begin
			y_s2    <= Y_W'(row_q) * Y_W'(GLYPH_ROWS) + Y_W'(r_q);
			col_s2  <= col_q;
			last_s2 <= last_row;

			prod_s3    <= PROD_W'(y_s2) * PROD_W'(pitch4);
			col_off_s3 <= COL_OFF_W'(col_s2) * COL_OFF_W'(CELL_BYTES);
			mask_s3    <= font_rdata;
			last_s3    <= last_s2;

			sum_s4  <= SUM_W'(prod_s3) + SUM_W'(col_off_s3);
			mask_s4 <= mask_s3;
			last_s4 <= last_s3;

			out_item.write_address <= cfg.base_address + ADDR_W'(sum_s4);
			out_item.ink_mask      <= mask_s4;
			out_item.last          <= last_s4;
		end
	end

	assign empty = !out_valid_q;

endmodule

// ===== hw/rtl/text_console_glyph_renderer.sv =====
`timescale 1ns / 1ps

// Text console renderer for a 32-bit-per-pixel framebuffer: 8x16 glyphs drawn in
// 9x16 cells. Load the font store first with font-load items (func 0); it is not
// cleared at reset, and printing a glyph whose rows were never loaded gives
// undefined ink masks. A print item (func 1) with a newline moves the cursor and
// gives no result; any other character gives GLYPH_ROWS row writes, one per
// cycle while the output is popped, the last marked by last. A printed character
// occupies the back end while the row sequencer reads its glyph rows through the
// single read port of the font memory; loads and newlines are handled in the
// front end alone. A two-entry queue sits between the front end and the back end,
// so the next items are taken while rows are still being written. A font load
// is held until every queued character has read its glyph rows. The rows of a
// character pass the font read, stages s2 to s4 and the output register.
// Configuration may only be written while the block is idle.
module text_console_glyph_renderer #(
	parameter int GLYPH_ROWS  = tcgr_pkg::DEF_GLYPH_ROWS,
	parameter int GLYPH_COUNT = tcgr_pkg::DEF_GLYPH_COUNT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  tcgr_pkg::in_item_t                    in_item,
	output logic                                  empty,
	input  logic                                  pop,
	output tcgr_pkg::out_item_t                   out_item,
	input  logic                                  cfg_write,
	input  logic [tcgr_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [tcgr_pkg::ADDR_W-1:0]           cfg_data
);

	import tcgr_pkg::*;

	localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
	localparam int FONT_AW    = $clog2(FONT_DEPTH);

	cfg_t               cfg_q;
	logic               job_push;
	logic               job_pop;
	job_t               push_job;
	job_t               head_job;
	logic               job_full;
	logic               job_empty;
	logic               back_active;
	logic               reads_idle;
	logic               font_we;
	logic [FONT_AW-1:0] font_waddr;
	logic [7:0]         font_wdata;
	logic               font_re;
	logic [FONT_AW-1:0] font_raddr;
	logic [7:0]         font_rdata;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_address  <= '0;
			cfg_q.pitch_bytes   <= 16'd4096;
			cfg_q.screen_width  <= 14'd1024;
			cfg_q.screen_height <= 14'd768;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_BASE_ADDRESS: begin
					cfg_q.base_address <= cfg_data;
				end
				REG_PITCH_BYTES: begin
					cfg_q.pitch_bytes <= cfg_data[15:0];
				end
				REG_SCREEN_WIDTH: begin
					cfg_q.screen_width <= cfg_data[13:0];
				end
				REG_SCREEN_HEIGHT: begin
					cfg_q.screen_height <= cfg_data[13:0];
				end
				default: begin
				end
			endcase
		end
	end

	// No glyph reads are outstanding once the queue is drained and the sequencer stops.
	assign reads_idle = job_empty && !back_active;

	tcgr_front #(
		.GLYPH_ROWS (GLYPH_ROWS),
		.GLYPH_COUNT(GLYPH_COUNT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_item   (in_item),
		.cfg       (cfg_q),
		.reads_idle(reads_idle),
		.job_full  (job_full),
		.job_push  (job_push),
		.job       (push_job),
		.font_we   (font_we),
		.font_waddr(font_waddr),
		.font_wdata(font_wdata)
	);

	tcgr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.push_job(push_job),
		.pop     (job_pop),
		.head_job(head_job),
		.full    (job_full),
		.empty   (job_empty)
	);

	tcgr_ram #(
		.WIDTH(8),
		.DEPTH(FONT_DEPTH)
	) u_font_ram (
		.clk  (clk),
		.we   (font_we),
		.waddr(font_waddr),
		.wdata(font_wdata),
		.re   (font_re),
		.raddr(font_raddr),
		.rdata(font_rdata)
	);

	tcgr_back #(
		.GLYPH_ROWS (GLYPH_ROWS),
		.GLYPH_COUNT(GLYPH_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head_job  (head_job),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.active    (back_active),
		.font_re   (font_re),
		.font_raddr(font_raddr),
		.font_rdata(font_rdata),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item)
	);

endmodule
